/* rtl/balanced_byte_alu_defines.svh */
// ----------------------------------------------------------------------------
// balanced_byte_alu_defines
// assertion macros shared by the checker of the balanced byte alu
// ----------------------------------------------------------------------------
`ifndef BALANCED_BYTE_ALU_DEFINES_SVH
`define BALANCED_BYTE_ALU_DEFINES_SVH

// clocked assertion, quiet while reset is high
`define BBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// types, operation codes and helpers of the balanced byte alu
// ----------------------------------------------------------------------------
package bba_pkg;

  // operation codes
  localparam logic [3:0] OP_ENCODE = 4'd0;
  localparam logic [3:0] OP_DECODE = 4'd1;
  localparam logic [3:0] OP_ADD    = 4'd2;
  localparam logic [3:0] OP_SUB    = 4'd3;
  localparam logic [3:0] OP_NEGATE = 4'd4;
  localparam logic [3:0] OP_XOR    = 4'd5;
  localparam logic [3:0] OP_MUL    = 4'd6;
  localparam logic [3:0] OP_UDIV   = 4'd7;
  localparam logic [3:0] OP_UREM   = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_WORD = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  // word layout
  localparam logic [31:0] RAIL_MASK = 32'h00ff00ff;

  // divider split: restoring steps per stage and number of stages
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = 8 / DIV_STEPS;

  // payload that travels down the pipeline
  typedef struct packed {
    logic [3:0] op;
    logic [1:0] status;
    logic [7:0] res;
    logic [7:0] divisor;
    logic [7:0] rem;
    logic [7:0] quo;
  } pipe_t;

  function automatic logic well_formed(input logic [31:0] w);
    return ((w & ~RAIL_MASK) == 32'd0) && (w[23:16] == ~w[7:0]);
  endfunction

  function automatic logic [31:0] encode_byte(input logic [7:0] x);
    return {8'h00, ~x, 8'h00, x};
  endfunction

endpackage

/* rtl/bba_front.sv */
// ----------------------------------------------------------------------------
// bba_front
// first stage: operand checks, short byte operations and divider setup
// ----------------------------------------------------------------------------
module bba_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          op,
  input  logic [31:0]         lhs,
  input  logic [31:0]         rhs,
  output logic                out_valid,
  input  logic                out_ready,
  output bba_pkg::pipe_t      out_data
);
  import bba_pkg::*;

  pipe_t       data;
  pipe_t       data_next;
  logic        valid;
  logic [7:0]  xa;
  logic [7:0]  ya;
  logic [15:0] prod;
  logic        uses_lhs;
  logic        uses_rhs;
  logic        bad;

  // operand checks and short operations
  always_comb begin
    xa       = lhs[7:0];
    ya       = rhs[7:0];
    prod     = 16'(xa) * 16'(ya);
    uses_lhs = (op >= OP_DECODE) && (op <= OP_UREM);
    uses_rhs = (op >= OP_ADD) && (op <= OP_UREM) && (op != OP_NEGATE);
    bad      = (uses_lhs && !well_formed(lhs)) || (uses_rhs && !well_formed(rhs));

    data_next.op      = op;
    data_next.divisor = ya;
    data_next.rem     = 8'd0;
    data_next.quo     = xa;
    data_next.status  = ST_OK;
    data_next.res     = 8'd0;
    case (op)
      OP_ENCODE, OP_DECODE: data_next.res = xa;
      OP_ADD:               data_next.res = xa + ya;
      OP_SUB:               data_next.res = xa - ya;
      OP_NEGATE:            data_next.res = 8'd0 - xa;
      OP_XOR:               data_next.res = xa ^ ya;
      OP_MUL:               data_next.res = prod[7:0];
      default:              data_next.res = 8'd0;
    endcase
    if (bad) begin
      data_next.status = ST_BAD_WORD;
    end else if (((op == OP_UDIV) || (op == OP_UREM)) && (ya == 8'd0)) begin
      data_next.status = ST_DIV_ZERO;
    end
  end

  // stage register
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* rtl/bba_div_stage.sv */
// ----------------------------------------------------------------------------
// bba_div_stage
// one divider stage: DIV_STEPS restoring division steps and a stage register
// ----------------------------------------------------------------------------
module bba_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bba_pkg::pipe_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bba_pkg::pipe_t out_data
);
  import bba_pkg::*;

  pipe_t      data;
  pipe_t      data_next;
  logic       valid;
  logic [8:0] shifted;
  logic       ge;

  // restoring steps: shift in the next dividend bit, subtract when it fits
  always_comb begin
    data_next = in_data;
    shifted   = 9'd0;
    ge        = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      shifted       = {data_next.rem, data_next.quo[7]};
      ge            = shifted >= {1'b0, data_next.divisor};
      data_next.rem = ge ? 8'(shifted - {1'b0, data_next.divisor}) : shifted[7:0];
      data_next.quo = {data_next.quo[6:0], ge};
    end
  end

  // stage register
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* rtl/balanced_byte_alu.sv */
// ----------------------------------------------------------------------------
// balanced_byte_alu: byte alu over balanced words (byte and its complement)
// check, divider and output registers; one request per cycle while not stalled
// the 8-step restoring divider sets the depth, two steps in each of 4 stages
// synchronous reset empties all stages; no state is kept between requests
// ----------------------------------------------------------------------------
module balanced_byte_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  op,
  input  logic [31:0] lhs,
  input  logic [31:0] rhs,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result,
  output logic [1:0]  status
);
  import bba_pkg::*;

  logic                  front_ready;
  logic [DIV_STAGES:0]   stg_valid;
  logic [DIV_STAGES:0]   stg_ready;
  pipe_t                 stg_data [DIV_STAGES+1];
  pipe_t                 last;
  logic                  out_ready;
  logic [31:0]           result_next;

  assign in_stall = !front_ready;

  // check stage
  bba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .op        (op),
    .lhs       (lhs),
    .rhs       (rhs),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  // divider stages
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    bba_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  // result formatting
  assign last = stg_data[DIV_STAGES];

  always_comb begin
    result_next = 32'd0;
    if (last.status == ST_OK) begin
      case (last.op)
        OP_DECODE: result_next = {24'd0, last.res};
        OP_ENCODE, OP_ADD, OP_SUB, OP_NEGATE, OP_XOR, OP_MUL:
          result_next = encode_byte(last.res);
        OP_UDIV:   result_next = encode_byte(last.quo);
        OP_UREM:   result_next = encode_byte(last.rem);
        default:   result_next = 32'd0;
      endcase
    end
  end

  // output register
  assign out_ready             = !out_valid || !out_stall;
  assign stg_ready[DIV_STAGES] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= stg_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && stg_valid[DIV_STAGES]) begin
      result <= result_next;
      status <= last.status;
    end
  end

endmodule

/* rtl/bba_checker.sv */
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the balanced byte alu, bound to the top level
// ----------------------------------------------------------------------------
`include "balanced_byte_alu_defines.svh"

module bba_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result,
  input logic [1:0]  status
);
  import bba_pkg::*;

  // a stalled result stays put
  `BBA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(result) && $stable(status), "stalled result changed")

  // nothing leaves right after reset
  `BBA_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // any error status comes with a zero word
  `BBA_ASSERT(a_err_zero, out_valid && (status != ST_OK) |-> (result == 32'd0) && ((status == ST_BAD_WORD) || (status == ST_DIV_ZERO)), "bad error result")

  // result words only use the two rails
  `BBA_ASSERT(a_rails_only, out_valid |-> (result[15:8] == 8'd0) && (result[31:24] == 8'd0), "stray bits in result")

endmodule

bind balanced_byte_alu bba_checker u_bba_checker (.*);
